@@ sv/pol_pkg.sv @@
`default_nettype none

package pol_pkg;

    localparam int unsigned DATA_W = 32;
    localparam int unsigned FUNC_W = 3;
    localparam int unsigned POS_W  = 5;
    localparam int unsigned LEN_W  = 5;

    localparam logic [FUNC_W-1:0] FUNC_INS_FRONT = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_INS_BACK  = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_INS_POS   = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_DEL_FRONT = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_DEL_BACK  = 3'd4;
    localparam logic [FUNC_W-1:0] FUNC_DEL_POS   = 3'd5;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2,
        ST_RANGE = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        CELL_HOLD = 2'd0,
        CELL_INS  = 2'd1,
        CELL_DEL  = 2'd2
    } t_cell_op;

    typedef struct packed {
        t_cell_op op;
    } t_cell_ctrl;

endpackage

`default_nettype wire

@@ sv/pol_cell.sv @@
`default_nettype none

module pol_cell #(
    parameter int unsigned IW  = 4,
    parameter int unsigned IDX = 0
) (
    input  wire logic                                  i_clk,
    input  wire pol_pkg::t_cell_ctrl                   i_ctrl,
    input  wire logic [IW-1:0]                         i_index,
    input  wire logic signed [pol_pkg::DATA_W-1:0]     i_new,
    input  wire logic signed [pol_pkg::DATA_W-1:0]     i_left,
    input  wire logic signed [pol_pkg::DATA_W-1:0]     i_right,
    output logic signed [pol_pkg::DATA_W-1:0]          o_value
);

    localparam logic [IW-1:0] MY_IDX = IW'(IDX);

    logic signed [pol_pkg::DATA_W-1:0] r_value;
    logic signed [pol_pkg::DATA_W-1:0] n_value;

    always_comb begin
        n_value = r_value;
        case (i_ctrl.op)
            pol_pkg::CELL_INS: begin
                if (MY_IDX == i_index) begin
                    n_value = i_new;
                end else if (MY_IDX > i_index) begin
                    n_value = i_left;
                end
            end
            pol_pkg::CELL_DEL: begin
                if (MY_IDX >= i_index) begin
                    n_value = i_right;
                end
            end
            default: begin
                n_value = r_value;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_value = r_value;

endmodule

`default_nettype wire

@@ sv/positional_ordered_list_top.sv @@
// A result word appears on the output in the cycle after its input word is accepted.
// Throughput: one word per cycle while o_ready is high; cells at and after the position shift in the accepting cycle.
// A new word enters only while the output register is empty or its word is taken that cycle.
// Reset clears the element count and the output valid; cell contents stay undefined.
`default_nettype none

module positional_ordered_list_top #(
    parameter int unsigned CAPACITY = 16
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_valid,
    output logic                                       o_ready,
    input  wire logic [pol_pkg::FUNC_W-1:0]            i_func,
    input  wire logic signed [pol_pkg::DATA_W-1:0]     i_value,
    input  wire logic [pol_pkg::POS_W-1:0]             i_position,
    output logic                                       o_valid,
    input  wire logic                                  i_ready,
    output logic signed [pol_pkg::DATA_W-1:0]          o_removed_value,
    output logic [1:0]                                 o_status,
    output logic [pol_pkg::LEN_W-1:0]                  o_length
);

    localparam int unsigned CW    = $clog2(CAPACITY + 1);
    localparam int unsigned IW    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int unsigned CMP_W = ((CW > pol_pkg::POS_W) ? CW : pol_pkg::POS_W) + 1;
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

    logic [CW-1:0]                      r_count;
    logic [CW-1:0]                      n_count;
    logic                               r_out_valid;
    logic signed [pol_pkg::DATA_W-1:0]  r_removed;
    logic signed [pol_pkg::DATA_W-1:0]  n_removed;
    pol_pkg::t_status                   r_status;
    pol_pkg::t_status                   n_status;
    logic [pol_pkg::LEN_W-1:0]          r_length;

    logic                               accept;
    logic                               full;
    logic                               empty;
    logic [CMP_W-1:0]                   pos_x;
    logic [CMP_W-1:0]                   cnt_x;
    logic [CMP_W-1:0]                   k_x;
    logic [IW-1:0]                      k_idx;
    pol_pkg::t_cell_op                  op_do;
    pol_pkg::t_cell_ctrl                cell_ctrl;

    logic signed [pol_pkg::DATA_W-1:0]  w_val [CAPACITY];

    assign o_ready = !r_out_valid || i_ready;
    assign accept  = i_valid && o_ready;
    assign full    = (r_count == CAP_C);
    assign empty   = (r_count == '0);
    assign pos_x   = CMP_W'(i_position);
    assign cnt_x   = CMP_W'(r_count);
    assign k_idx   = k_x[IW-1:0];

    always_comb begin
        n_status = pol_pkg::ST_OK;
        op_do    = pol_pkg::CELL_HOLD;
        k_x      = '0;
        case (i_func)
            pol_pkg::FUNC_INS_FRONT: begin
                if (full) begin
                    n_status = pol_pkg::ST_FULL;
                end else begin
                    op_do = pol_pkg::CELL_INS;
                end
            end
            pol_pkg::FUNC_INS_BACK: begin
                if (full) begin
                    n_status = pol_pkg::ST_FULL;
                end else begin
                    op_do = pol_pkg::CELL_INS;
                    k_x   = cnt_x;
                end
            end
            pol_pkg::FUNC_INS_POS: begin
                if (full) begin
                    n_status = pol_pkg::ST_FULL;
                end else if (pos_x == '0 || pos_x > cnt_x + CMP_W'(1)) begin
                    n_status = pol_pkg::ST_RANGE;
                end else begin
                    op_do = pol_pkg::CELL_INS;
                    k_x   = pos_x - CMP_W'(1);
                end
            end
            pol_pkg::FUNC_DEL_FRONT: begin
                if (empty) begin
                    n_status = pol_pkg::ST_EMPTY;
                end else begin
                    op_do = pol_pkg::CELL_DEL;
                end
            end
            pol_pkg::FUNC_DEL_BACK: begin
                if (empty) begin
                    n_status = pol_pkg::ST_EMPTY;
                end else begin
                    op_do = pol_pkg::CELL_DEL;
                    k_x   = cnt_x - CMP_W'(1);
                end
            end
            pol_pkg::FUNC_DEL_POS: begin
                if (empty) begin
                    n_status = pol_pkg::ST_EMPTY;
                end else if (pos_x == '0 || pos_x > cnt_x) begin
                    n_status = pol_pkg::ST_RANGE;
                end else begin
                    op_do = pol_pkg::CELL_DEL;
                    k_x   = pos_x - CMP_W'(1);
                end
            end
            default: begin
                n_status = pol_pkg::ST_OK;
            end
        endcase
    end

    assign cell_ctrl.op = accept ? op_do : pol_pkg::CELL_HOLD;

    always_comb begin
        n_removed = '0;
        if (op_do == pol_pkg::CELL_DEL) begin
            n_removed = w_val[k_idx];
        end
    end

    always_comb begin
        case (op_do)
            pol_pkg::CELL_INS: n_count = r_count + CW'(1);
            pol_pkg::CELL_DEL: n_count = r_count - CW'(1);
            default:           n_count = r_count;
        endcase
    end

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic signed [pol_pkg::DATA_W-1:0] left_val;
        logic signed [pol_pkg::DATA_W-1:0] right_val;

        if (g == 0) begin : g_first
            assign left_val = '0;
        end else begin : g_mid_l
            assign left_val = w_val[g-1];
        end

        if (g == CAPACITY - 1) begin : g_last
            assign right_val = '0;
        end else begin : g_mid_r
            assign right_val = w_val[g+1];
        end

        pol_cell #(
            .IW  (IW),
            .IDX (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_ctrl  (cell_ctrl),
            .i_index (k_idx),
            .i_new   (i_value),
            .i_left  (left_val),
            .i_right (right_val),
            .o_value (w_val[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_removed <= n_removed;
            r_status  <= n_status;
            r_length  <= pol_pkg::LEN_W'(n_count);
        end
    end

    assign o_valid         = r_out_valid;
    assign o_removed_value = r_removed;
    assign o_status        = r_status;
    assign o_length        = r_length;

endmodule

`default_nettype wire

@@ sv/pol_chk.sv @@
`default_nettype none

module pol_chk #(
    parameter int unsigned CAPACITY = 16
) (
    input wire logic                                  i_clk,
    input wire logic                                  i_rst_n,
    input wire logic                                  i_valid,
    input wire logic                                  o_ready,
    input wire logic                                  o_valid,
    input wire logic                                  i_ready,
    input wire logic signed [pol_pkg::DATA_W-1:0]     o_removed_value,
    input wire logic [1:0]                            o_status,
    input wire logic [pol_pkg::LEN_W-1:0]             o_length
);

    localparam logic [pol_pkg::LEN_W-1:0] CAP_LEN = pol_pkg::LEN_W'(CAPACITY);

    // A stalled result word holds its value.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_removed_value)
            && $stable(o_status) && $stable(o_length))
        else $error("result word changed while stalled");

    a_accept_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> o_valid)
        else $error("accepted word produced no result");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status != 2'(pol_pkg::ST_OK) |-> o_removed_value == '0)
        else $error("error result carries a removed value");

    a_empty_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == 2'(pol_pkg::ST_EMPTY) |-> o_length == '0)
        else $error("empty status with nonzero length");

    a_full_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == 2'(pol_pkg::ST_FULL) |-> o_length == CAP_LEN)
        else $error("full status with length below capacity");

endmodule

bind positional_ordered_list_top pol_chk #(
    .CAPACITY (CAPACITY)
) u_pol_chk (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_valid         (i_valid),
    .o_ready         (o_ready),
    .o_valid         (o_valid),
    .i_ready         (i_ready),
    .o_removed_value (o_removed_value),
    .o_status        (o_status),
    .o_length        (o_length)
);

`default_nettype wire

@@ bench/pol_checker.sv @@
module pol_checker
    import pol_pkg::*;
#(
    parameter int unsigned CAPACITY = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_in_valid,
    input  wire logic                     i_in_ready,
    input  wire logic [FUNC_W-1:0]        i_func,
    input  wire logic signed [DATA_W-1:0] i_value,
    input  wire logic [POS_W-1:0]         i_position,
    input  wire logic                     i_out_valid,
    input  wire logic                     i_out_ready,
    input  wire logic signed [DATA_W-1:0] i_removed_value,
    input  wire logic [1:0]               i_status,
    input  wire logic [LEN_W-1:0]         i_length,
    output int                            o_mismatches,
    output int                            o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic signed [DATA_W-1:0] removed;
        t_status                  status;
        logic [LEN_W-1:0]         length;
    } list_result_t;

    logic signed [DATA_W-1:0] model_list[$];
    list_result_t             expected_results[$];
    int                       mismatch_total = 0;

    function automatic list_result_t apply_list_op(
        input logic [FUNC_W-1:0]        func,
        input logic signed [DATA_W-1:0] value,
        input logic [POS_W-1:0]         position
    );
        list_result_t res;
        int unsigned  count;
        int unsigned  pos;
        count       = model_list.size();
        pos         = 32'(position);
        res.removed = '0;
        res.status  = ST_OK;
        case (func)
            FUNC_INS_FRONT, FUNC_INS_BACK, FUNC_INS_POS: begin
                if (count >= CAPACITY) begin
                    res.status = ST_FULL;
                end else if (func == FUNC_INS_FRONT) begin
                    model_list.push_front(value);
                end else if (func == FUNC_INS_BACK) begin
                    model_list.push_back(value);
                end else if (pos < 1 || pos > count + 1) begin
                    res.status = ST_RANGE;
                end else begin
                    model_list.insert(pos - 1, value);
                end
            end
            FUNC_DEL_FRONT, FUNC_DEL_BACK, FUNC_DEL_POS: begin
                if (count == 0) begin
                    res.status = ST_EMPTY;
                end else if (func == FUNC_DEL_FRONT) begin
                    res.removed = model_list.pop_front();
                end else if (func == FUNC_DEL_BACK) begin
                    res.removed = model_list.pop_back();
                end else if (pos < 1 || pos > count) begin
                    res.status = ST_RANGE;
                end else begin
                    res.removed = model_list[pos - 1];
                    model_list.delete(pos - 1);
                end
            end
            default: begin
            end
        endcase
        res.length = LEN_W'(model_list.size());
        return res;
    endfunction

    always @(posedge i_clk) begin
        list_result_t want;
        if (i_rst_n) begin
            // A result word always belongs to an earlier input word, so it is
            // checked before the word accepted at this same edge is predicted.
            if (i_out_valid && i_out_ready) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result word: removed %0d status %0d length %0d",
                             $time, i_removed_value, i_status, i_length);
                    mismatch_total++;
                end else begin
                    want = expected_results.pop_front();
                    if (i_removed_value !== want.removed || i_status !== want.status
                            || i_length !== want.length) begin
                        $display("%0t: expected removed %0d status %0d length %0d, got removed %0d status %0d length %0d",
                                 $time, want.removed, want.status, want.length,
                                 i_removed_value, i_status, i_length);
                        mismatch_total++;
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                expected_results.push_back(apply_list_op(i_func, i_value, i_position));
            end
        end
        o_pending    <= expected_results.size();
        o_mismatches <= mismatch_total;
    end

endmodule

@@ bench/tb.sv @@
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pol_pkg::*;

    localparam int unsigned CAPACITY        = 16;
    localparam int unsigned CLK_HALF        = 4;
    localparam int unsigned RESET_CYCLES    = 11;
    localparam int unsigned RANDOM_WORDS    = 700;
    localparam int unsigned IDLE_PCT        = 29;
    localparam int unsigned SEGMENT_WORDS   = 40;
    localparam int unsigned FORCED_HOLD_AT  = 200;
    localparam int unsigned FORCED_HOLD_LEN = 64;
    localparam int unsigned DRAIN_CYCLES    = 4;
    localparam longint      TIMEOUT_NS      = 2_000_000;

    localparam logic [FUNC_W-1:0] FUNC_UNUSED_A = 3'd6;
    localparam logic [FUNC_W-1:0] FUNC_UNUSED_B = 3'd7;

    localparam logic signed [DATA_W-1:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [DATA_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;

    logic                     i_clk      = 1'b0;
    logic                     i_rst_n    = 1'b0;
    logic                     i_valid    = 1'b0;
    logic                     i_ready    = 1'b0;
    logic [FUNC_W-1:0]        i_func     = '0;
    logic signed [DATA_W-1:0] i_value    = '0;
    logic [POS_W-1:0]         i_position = '0;
    logic                     o_ready;
    logic                     o_valid;
    logic signed [DATA_W-1:0] o_removed_value;
    logic [1:0]               o_status;
    logic [LEN_W-1:0]         o_length;

    int mismatches;
    int outstanding;
    bit send_gaps = 1'b1;

    positional_ordered_list_top #(
        .CAPACITY(CAPACITY)
    ) uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_func         (i_func),
        .i_value        (i_value),
        .i_position     (i_position),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_removed_value(o_removed_value),
        .o_status       (o_status),
        .o_length       (o_length)
    );

    pol_checker #(
        .CAPACITY(CAPACITY)
    ) u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_valid),
        .i_in_ready     (o_ready),
        .i_func         (i_func),
        .i_value        (i_value),
        .i_position     (i_position),
        .i_out_valid    (o_valid),
        .i_out_ready    (i_ready),
        .i_removed_value(o_removed_value),
        .i_status       (o_status),
        .i_length       (o_length),
        .o_mismatches   (mismatches),
        .o_pending      (outstanding)
    );

    always #(CLK_HALF) i_clk = ~i_clk;

    initial begin
        #(TIMEOUT_NS);
        $display("Some tests failed");
        $finish;
    end

    task automatic send_word(
        input logic [FUNC_W-1:0]        func,
        input logic signed [DATA_W-1:0] value,
        input logic [POS_W-1:0]         position
    );
        while (send_gaps && $urandom_range(0, 99) < IDLE_PCT) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid    <= 1'b1;
        i_func     <= func;
        i_value    <= value;
        i_position <= position;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
    endtask

    // Result side: random idling, one quiet stretch, occasional long hold-offs
    // and one forced hold-off that backs the block up while words keep coming.
    initial begin
        int unsigned cyc;
        int unsigned hold_left;
        cyc       = 0;
        hold_left = 0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (cyc == FORCED_HOLD_AT) begin
                hold_left = FORCED_HOLD_LEN;
            end else if (hold_left == 0 && $urandom_range(0, 599) == 0) begin
                hold_left = $urandom_range(20, 60);
            end
            if (hold_left != 0) begin
                i_ready <= 1'b0;
                hold_left--;
            end else if (cyc >= 600 && cyc < 900) begin
                i_ready <= 1'b1;
            end else begin
                i_ready <= ($urandom_range(0, 99) >= IDLE_PCT);
            end
            cyc++;
            @(posedge i_clk);
        end
    end

    initial begin
        logic [FUNC_W-1:0]        func;
        logic signed [DATA_W-1:0] value;
        logic [POS_W-1:0]         position;
        int unsigned              pick;
        int unsigned              ins_pct;
        bit                       filling;

        filling = 1'b0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_word(FUNC_DEL_FRONT, VAL_MAX, 5'd1);
        send_word(FUNC_DEL_BACK, VAL_MIN, 5'd1);
        send_word(FUNC_DEL_POS, 32'sd0, 5'd0);
        send_word(FUNC_UNUSED_A, -32'sd1, 5'd31);
        send_word(FUNC_UNUSED_B, 32'sd5, 5'd16);
        send_word(FUNC_INS_POS, 32'sd7, 5'd0);
        send_word(FUNC_INS_POS, 32'sd7, 5'd2);
        send_word(FUNC_INS_POS, VAL_MIN, 5'd1);
        send_word(FUNC_INS_FRONT, VAL_MAX, 5'd31);
        send_word(FUNC_INS_BACK, 32'sd0, 5'd0);
        send_word(FUNC_INS_BACK, -32'sd1, 5'd16);
        send_word(FUNC_INS_POS, 32'sh1234_5678, 5'd5);
        send_word(FUNC_INS_POS, 32'sh0BAD_F00D, 5'd6);
        send_word(FUNC_DEL_POS, 32'sd0, 5'd1);
        send_word(FUNC_DEL_POS, 32'sd0, 5'd5);
        send_word(FUNC_DEL_POS, 32'sd0, 5'd4);
        send_word(FUNC_DEL_POS, 32'sd0, 5'd0);
        send_word(FUNC_DEL_BACK, 32'sd0, 5'd0);
        send_word(FUNC_DEL_FRONT, 32'sd0, 5'd0);
        send_word(FUNC_DEL_POS, VAL_MAX, 5'd1);
        send_word(FUNC_DEL_BACK, 32'sd0, 5'd0);

        // Alternate between filling and draining so the list keeps reaching
        // both the full and the empty state.
        for (int n = 0; n < RANDOM_WORDS; n++) begin
            send_gaps = !(n >= 300 && n < 420);
            if (n % SEGMENT_WORDS == 0) begin
                filling = ~filling;
            end
            ins_pct = filling ? 70 : 25;
            pick    = $urandom_range(0, 99);
            if (pick < 5) begin
                func = $urandom_range(0, 1) ? FUNC_UNUSED_A : FUNC_UNUSED_B;
            end else if (pick < 5 + ins_pct) begin
                case ($urandom_range(0, 2))
                    0: func = FUNC_INS_FRONT;
                    1: func = FUNC_INS_BACK;
                    default: func = FUNC_INS_POS;
                endcase
            end else begin
                case ($urandom_range(0, 2))
                    0: func = FUNC_DEL_FRONT;
                    1: func = FUNC_DEL_BACK;
                    default: func = FUNC_DEL_POS;
                endcase
            end
            case ($urandom_range(0, 9))
                0: value = VAL_MIN;
                1: value = VAL_MAX;
                2: value = '0;
                3: value = -32'sd1;
                default: value = $urandom;
            endcase
            pick = $urandom_range(0, 99);
            if (pick < 8) begin
                position = '0;
            end else if (pick < 13) begin
                position = POS_W'($urandom_range(CAPACITY + 2, 31));
            end else begin
                position = POS_W'($urandom_range(1, CAPACITY + 1));
            end
            send_word(func, value, position);
        end

        i_valid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && outstanding == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
